@@ hw/rtl/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern search.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  // Pattern bytes carried by the configuration registers.
  localparam int CFG_BYTES   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 5;
  localparam int MASK_W      = 16;
  localparam int RES_OFFS_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 2'd3;

  // Active configuration as seen by the scan stage; len is already clamped.
  typedef struct packed {
    logic [CFG_BYTES-1:0][7:0] pattern;
    logic [MASK_W-1:0]         mask;
    logic [LEN_W-1:0]          len;
  } cfg_t;

  typedef struct packed {
    logic                  found;
    logic [RES_OFFS_W-1:0] offset;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/wildcard_byte_pattern_search.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search: first match of a wildcard byte pattern.
// A result is registered from its byte: the byte sits in the input register
// while the compare feeds the result register.
// Throughput: one byte per cycle; a result held by the receiver stops the
// input register, and the input stalls while that register is full.
// Reset clears the scan state and sets the configuration to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  last_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       found_o,
  output logic [RES_OFFS_W-1:0]      match_offset_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    res_valid;
  logic    s1_valid_q;
  logic [7:0] s1_data_q;
  logic    s1_last_q;
  logic    out_valid_q;
  logic    advance;
  logic    step;

  // The result register is free when empty or being taken this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  wbps_cfg #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  wbps_scan #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .data_byte_i(s1_data_q),
    .last_byte_i(s1_last_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid_o    = out_valid_q;
  assign found_o        = res_q.found;
  assign match_offset_o = res_q.offset;

  // The input side only stalls while a byte waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // A new result always comes from a byte held in the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a byte to cause it");

  // A not-found result carries a zero offset.
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.found) |-> (res_q.offset == '0))
    else $error("not-found result with a nonzero offset");

endmodule

`default_nettype wire

@@ hw/rtl/wbps_cfg.sv @@
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers and clamping of the pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  localparam int CAP = (MAX_PATTERN_BYTES < CFG_BYTES) ? MAX_PATTERN_BYTES : CFG_BYTES;

  logic [CFG_DATA_W-1:0] pat_low_q;
  logic [CFG_DATA_W-1:0] pat_high_q;
  logic [MASK_W-1:0]     mask_q;
  logic [LEN_W-1:0]      len_q;
  logic [LEN_W-1:0]      len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '0;
      len_q      <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN_LOW:  pat_low_q  <= cfg_wdata_i;
        REG_PATTERN_HIGH: pat_high_q <= cfg_wdata_i;
        REG_WILDCARD:     mask_q     <= cfg_wdata_i[MASK_W-1:0];
        REG_LENGTH:       len_q      <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length behaves as one; a length beyond the window is clamped.
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(CAP)) begin
      len_eff = LEN_W'(CAP);
    end else begin
      len_eff = len_q;
    end
  end

  assign cfg_o.pattern = {pat_high_q, pat_low_q};
  assign cfg_o.mask    = mask_q;
  assign cfg_o.len     = len_eff;

endmodule

`default_nettype wire

@@ hw/rtl/wbps_scan.sv @@
// ----------------------------------------------------------------------------
// wbps_scan
// Sliding byte window, position counter and masked window compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_scan
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire cfg_t       cfg_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  // Only the newest WIN bytes can ever take part in a compare.
  localparam int WIN   = (MAX_PATTERN_BYTES < CFG_BYTES) ? MAX_PATTERN_BYTES : CFG_BYTES;
  localparam int WIN_W = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int FILL_W = $clog2(WIN + 1);

  logic [WIN-1:0][7:0]     win_q;
  logic [WIN-1:0][7:0]     win_d;
  logic [FILL_W-1:0]       fill_q;
  logic [FILL_W-1:0]       fill_d;
  logic [OFFSET_BITS-1:0]  pos_q;
  logic                    done_q;
  logic                    mismatch;
  logic                    hit;
  logic [OFFSET_BITS-1:0]  start;

  always_comb begin
    win_d[0] = data_byte_i;
    for (int k = 1; k < WIN; k++) begin
      win_d[k] = win_q[k-1];
    end
    fill_d = (fill_q == FILL_W'(WIN)) ? fill_q : fill_q + FILL_W'(1);
  end

  // Pattern byte i lines up with window entry len-1-i, entry 0 being newest.
  always_comb begin
    logic [LEN_W-1:0] lag;
    mismatch = 1'b0;
    for (int i = 0; i < WIN; i++) begin
      lag = cfg_i.len - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < cfg_i.len) && !cfg_i.mask[i] &&
          (win_d[lag[WIN_W-1:0]] != cfg_i.pattern[i])) begin
        mismatch = 1'b1;
      end
    end
    hit   = (32'(fill_d) >= 32'(cfg_i.len)) && !mismatch;
    start = pos_q - OFFSET_BITS'(cfg_i.len) + OFFSET_BITS'(1);
  end

  always_comb begin
    res_valid_o   = step_i && !done_q && (hit || last_byte_i);
    res_o.found   = hit;
    res_o.offset  = hit ? RES_OFFS_W'(start) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        // End of image: the next byte starts a new scan.
        fill_q <= '0;
        pos_q  <= '0;
        done_q <= 1'b0;
      end else if (!done_q) begin
        fill_q <= fill_d;
        pos_q  <= pos_q + OFFSET_BITS'(1);
        done_q <= hit;
      end
    end
  end

  // Entries at or beyond the fill count are never compared, so no reset.
  always_ff @(posedge clk_i) begin
    if (step_i && !done_q) begin
      win_q <= win_d;
    end
  end

endmodule

`default_nettype wire

@@ bench/wildcard_byte_pattern_search_test.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_test
// Streams byte images through the pattern search and compares every found
// and not-found transaction with a cycle-free prediction of the scan. The
// images embed the configured pattern, broken copies of it and lookalike
// bytes, under random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int WINDOW_BYTES = 16;
  localparam int WAIT_MAX     = 15;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 560;
  localparam int MIN_RESULTS  = 48;
  localparam int PRINT_LIMIT  = 40;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  last_byte_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  found_o;
  logic [RES_OFFS_W-1:0] match_offset_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Configuration copy and scan state of the prediction.
  logic [127:0] pat_bytes;
  logic [15:0]  wild_bits;
  logic [4:0]   len_reg;
  logic [7:0]   win_bytes [WINDOW_BYTES];
  logic [31:0]  next_pos;
  int unsigned  fill_cnt;
  bit           scan_done;

  result_t expected_results [$];

  int unsigned in_idle_pct   = 50;
  int unsigned out_idle_pct  = 50;
  int unsigned hold_req      = 0;
  int unsigned stall_left    = 0;
  bit          out_taken     = 1'b0;

  int unsigned mismatches    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned live_bytes    = 0;
  int unsigned results_made  = 0;
  int unsigned found_seen    = 0;
  int unsigned missed_seen   = 0;
  int unsigned configs_done  = 0;

  always #4 clk_i = ~clk_i;

  wildcard_byte_pattern_search uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  function automatic int unsigned draw_wait(input int unsigned pct);
    if ($urandom_range(99) < pct) return $urandom_range(WAIT_MAX);
    return 0;
  endfunction

  function automatic int unsigned used_length();
    int unsigned len;
    len = len_reg;
    if (len == 0) len = 1;
    if (len > WINDOW_BYTES) len = WINDOW_BYTES;
    return len;
  endfunction

  function automatic void clear_scan_state();
    for (int k = 0; k < WINDOW_BYTES; k++) win_bytes[k] = 8'h00;
    next_pos  = '0;
    fill_cnt  = 0;
    scan_done = 1'b0;
  endfunction

  // Advances the predicted scan by one byte; returns 1 when a result is due.
  function automatic bit scan_byte(input logic [7:0] data, input bit last,
                                   output result_t res);
    int unsigned len;
    logic [31:0] here;
    bit          hit;
    bit          has_res;
    has_res = 1'b0;
    res     = '0;
    if (!scan_done) begin
      len  = used_length();
      here = next_pos;
      for (int k = WINDOW_BYTES - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = data;
      if (fill_cnt < WINDOW_BYTES) fill_cnt++;
      next_pos = next_pos + 32'd1;
      if (fill_cnt >= len) begin
        hit = 1'b1;
        // Pattern byte i lines up with the byte that arrived len-1-i steps ago.
        for (int i = 0; i < len; i++) begin
          if (!wild_bits[i] && win_bytes[len-1-i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          res.found  = 1'b1;
          res.offset = here - (len - 1);
          has_res    = 1'b1;
          scan_done  = 1'b1;
        end
      end
      if (!has_res && last) begin
        res.found  = 1'b0;
        res.offset = '0;
        has_res    = 1'b1;
      end
    end
    if (last) clear_scan_state();
    return has_res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // Sends one image byte; entered and left at a rising edge. Valid stays high
  // afterwards so that back-to-back transactions need no second assignment.
  task automatic send_byte(input logic [7:0] data, input bit last);
    int unsigned gap;
    bit          taken;
    result_t     res;
    gap = draw_wait(in_idle_pct);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    bytes_sent++;
    if (!scan_done) live_bytes++;
    if (scan_byte(data, last, res)) begin
      expected_results.push_back(res);
      results_made++;
    end
  endtask

  // Waits until every predicted result has been checked and the pipeline
  // has had time to show any result that was not predicted.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [63:0] mask_word, input logic [63:0] len_word);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PATTERN_LOW;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= REG_PATTERN_HIGH;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_idx_i   <= REG_WILDCARD;
    cfg_wdata_i <= mask_word;
    @(posedge clk_i);
    cfg_idx_i   <= REG_LENGTH;
    cfg_wdata_i <= len_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pat_bytes = {hi, lo};
    wild_bits = mask_word[15:0];
    len_reg   = len_word[4:0];
    configs_done++;
  endtask

  // Pacing is changed at a falling edge so the output side never races it.
  task automatic set_pacing(input int unsigned in_pct, input int unsigned out_pct);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    hold_req = cycles;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] lookalike_byte();
    if ($urandom_range(1)) return pat_bytes[8*$urandom_range(WINDOW_BYTES-1) +: 8];
    return 8'($urandom_range(255));
  endfunction

  // Builds one image: lookalike bytes, optionally a copy of the pattern with
  // random bytes under the wildcards (possibly corrupted), and a short tail.
  task automatic send_image(input bit close);
    logic [7:0]  img [$];
    logic [7:0]  b;
    int unsigned len;
    int unsigned kind;
    int unsigned spoil;
    len  = used_length();
    kind = $urandom_range(9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 24)) img.push_back(lookalike_byte());
    end else begin
      repeat ($urandom_range(0, 12)) img.push_back(lookalike_byte());
      spoil = (kind >= 6) ? $urandom_range(len - 1) : WINDOW_BYTES;
      for (int i = 0; i < len; i++) begin
        b = wild_bits[i] ? 8'($urandom_range(255)) : pat_bytes[8*i +: 8];
        if (i == spoil) b = b ^ (8'h01 << $urandom_range(7));
        img.push_back(b);
      end
      repeat ($urandom_range(0, 4)) img.push_back(lookalike_byte());
    end
    for (int n = 0; n < img.size(); n++) send_byte(img[n], close && n == img.size() - 1);
  endtask

  // Output side: idles a random number of cycles before each transaction,
  // or for the whole length of a requested hold.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end else if (out_taken) begin
      stall_left = draw_wait(out_idle_pct);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(negedge clk_i) begin
    result_t want;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (out_taken) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, offset", '0, match_offset_o);
      end else begin
        want = expected_results.pop_front();
        if (found_o !== want.found) report_mismatch("found", want.found, found_o);
        if (match_offset_o !== want.offset)
          report_mismatch("match_offset", want.offset, match_offset_o);
        if (want.found) found_seen++;
        else missed_seen++;
      end
    end
  end

  task automatic test_reset_defaults();
    // Length 1, pattern byte zero, no wildcards.
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7E, 1'b1);
    settle();
  endtask

  task automatic test_length_zero();
    set_config(64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
  endtask

  task automatic test_wildcards_and_short_image();
    set_config(64'h0000_0000_00CD_00AB, 64'h0, 64'h2, 64'd3);
    // Image shorter than the pattern ends with not found.
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b1);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h5E, 1'b0);
    send_byte(8'hCD, 1'b1);
    settle();
  endtask

  task automatic test_byte_extremes();
    set_config(64'h0000_0000_0000_00FF, 64'h0, 64'hFFFF_FFFF_FFFF_0000, 64'd2);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b1);
    settle();
  endtask

  task automatic test_config_midscan();
    set_config(64'h0000_0000_0000_5612, 64'h0, 64'h0, 64'd2);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    settle();
    // The window keeps its bytes; the new pattern applies from the next byte.
    set_config(64'h0000_0000_0000_5634, 64'h0, 64'h0, 64'd2);
    send_byte(8'h56, 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    set_config(64'h0, 64'h0, 64'h1, 64'd1);
    set_pacing(0, 0);
    hold_receiver(300);
    // Every byte closes a one-byte image and matches through the wildcard.
    repeat (48) send_byte(8'($urandom_range(255)), 1'b1);
    settle();
  endtask

  task automatic test_random_images();
    int unsigned phase;
    int unsigned start_sent;
    int unsigned start_res;
    int unsigned images;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mw;
    logic [63:0] lw;
    phase      = 0;
    start_sent = bytes_sent;
    start_res  = results_made;
    while (bytes_sent - start_sent < RANDOM_ITEMS || results_made - start_res < MIN_RESULTS)
    begin
      settle();
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      mw = {$urandom, $urandom} & {$urandom, $urandom};
      lw = 64'($urandom_range(1, 16));
      case (phase % 8)
        0: begin
          mw = 64'h0;
          lw = 64'd16;
        end
        1: begin
          mw = 64'h0;
          lw = 64'd1;
        end
        2: lw = 64'd0;
        3: lw = 64'($urandom_range(17, 31));
        4: begin
          lo = '1;
          hi = '1;
          mw = 64'h0;
        end
        5: begin
          lo = '0;
          hi = '0;
          mw = 64'hFFFF;
          lw = 64'd16;
        end
        default: lw = {$urandom, $urandom} & ~64'h1F | lw;
      endcase
      set_config(lo, hi, mw, lw);
      set_pacing((phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 30 : 100,
                 (phase % 4 == 0) ? 100 : (phase % 4 == 2) ? 0 : 40);
      images = $urandom_range(3, 8);
      // Now and then the last image stays open across the next setting.
      for (int n = 0; n < images; n++) send_image(n != images - 1 || $urandom_range(3) != 0);
      phase++;
    end
    // Close any image left open.
    send_byte(8'($urandom_range(255)), 1'b1);
    settle();
  endtask

  initial begin
    pat_bytes = '0;
    wild_bits = '0;
    len_reg   = 5'd1;
    clear_scan_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_length_zero();
    test_wildcards_and_short_image();
    test_byte_extremes();
    test_config_midscan();
    test_backpressure();
    test_random_images();
    settle();
    $display("covered %0d bytes (%0d before a result) over %0d register settings",
             bytes_sent, live_bytes, configs_done);
    $display("checked %0d matches and %0d not-found results, %0d mismatches",
             found_seen, missed_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_cfg.sv
hw/rtl/wbps_scan.sv
hw/rtl/wildcard_byte_pattern_search.sv
bench/wildcard_byte_pattern_search_test.sv
